### rtl/core/btda_pkg.sv
// ----------------------------------------------------------------------------
// btda_pkg
// Shared types and constants for the binary to decimal ASCII formatter.
// ----------------------------------------------------------------------------
package btda_pkg;

	// decimal digit layout
	localparam int NUM_DIGITS   = 5;
	localparam int DIGIT_W      = 4;
	localparam int BCD_W        = NUM_DIGITS * DIGIT_W;
	localparam int IDX_W        = 3;
	localparam int VALUE_W      = 16;
	localparam int ASCII_W      = 6;

	// index of the top digit per width mode
	localparam logic [IDX_W-1:0] TOP_IDX_HALFWORD = IDX_W'(4);
	localparam logic [IDX_W-1:0] TOP_IDX_BYTE     = IDX_W'(2);

	// ascii code of the digit zero
	localparam logic [ASCII_W-1:0] ASCII_ZERO = ASCII_W'(48);

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// one converted item waiting for the emitter
	typedef struct packed {
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
		logic [IDX_W-1:0]                   start;
	} conv_entry_t;

endpackage

### rtl/core/btda_front.sv
// ----------------------------------------------------------------------------
// btda_front
// Input side: accepts a transaction, converts the value to BCD four bits a
// cycle and works out the first digit to send.
// ----------------------------------------------------------------------------
module btda_front
	import btda_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [VALUE_W-1:0]  value,
	input  logic                halfword_mode,
	input  logic                keep_leading_zeros,
	output logic                push,
	output conv_entry_t         push_entry,
	input  logic                queue_full
);

	// four shift-add-three steps, one input bit each
	function automatic logic [BCD_W-1:0] dabble4(input logic [BCD_W-1:0] bcd_in,
		input logic [3:0] bits);
		logic [BCD_W-1:0] b;
		b = bcd_in;
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
					b[d*DIGIT_W +: DIGIT_W] = b[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
				end
			end
			b = {b[BCD_W-2:0], bits[3-s]};
		end
		return b;
	endfunction

	logic               busy_q;
	logic [2:0]         steps_q;
	logic [VALUE_W-1:0] sh_q;
	logic [BCD_W-1:0]   bcd_q;
	logic               hw_q;
	logic               keep_q;
	logic               accept;
	logic [IDX_W-1:0]   start;

	// stall while converting or while the finished item cannot be queued
	assign in_stall = busy_q && !((steps_q == 3'd0) && !queue_full);
	assign accept   = in_valid && !in_stall;
	assign push     = busy_q && (steps_q == 3'd0) && !queue_full;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= 3'd0;
		end else if (accept) begin
			busy_q  <= 1'b1;
			steps_q <= halfword_mode ? 3'd4 : 3'd2;
		end else begin
			if (push) begin
				busy_q <= 1'b0;
			end
			if (busy_q && (steps_q != 3'd0)) begin
				steps_q <= steps_q - 3'd1;
			end
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q   <= halfword_mode ? value : {value[7:0], 8'h00};
			bcd_q  <= '0;
			hw_q   <= halfword_mode;
			keep_q <= keep_leading_zeros;
		end else if (busy_q && (steps_q != 3'd0)) begin
			bcd_q <= dabble4(bcd_q, sh_q[VALUE_W-1 -: 4]);
			sh_q  <= {sh_q[VALUE_W-5:0], 4'h0};
		end
	end

	// first digit to send: top digit when zeros are kept, else highest nonzero or units
	always_comb begin
		start = '0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (bcd_q[d*DIGIT_W +: DIGIT_W] != '0) begin
				start = IDX_W'(d);
			end
		end
		if (keep_q) begin
			start = hw_q ? TOP_IDX_HALFWORD : TOP_IDX_BYTE;
		end
	end

	assign push_entry.digits = bcd_q;
	assign push_entry.start  = start;

endmodule

### rtl/core/btda_queue.sv
// ----------------------------------------------------------------------------
// btda_queue
// Small queue between the converter and the character emitter.
// ----------------------------------------------------------------------------
module btda_queue
	import btda_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  conv_entry_t wr_data,
	output logic        full,
	input  logic        rd_en,
	output conv_entry_t rd_data,
	output logic        rd_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	conv_entry_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/btda_back.sv
// ----------------------------------------------------------------------------
// btda_back
// Output side: walks the digits of a queued item from the first digit sent
// down to the units digit, one character per transaction.
// ----------------------------------------------------------------------------
module btda_back
	import btda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  conv_entry_t        q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ASCII_W-1:0] ascii_digit,
	output logic               last_digit
);

	logic                               active_q;
	logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_q;
	logic [IDX_W-1:0]                   idx_q;
	logic                               out_valid_q;
	logic [ASCII_W-1:0]                 ascii_q;
	logic                               last_q;
	logic                               load_ok;
	logic                               finishing;

	// output register free or being drained this cycle
	assign load_ok   = !out_valid_q || !out_stall;
	assign finishing = active_q && load_ok && (idx_q == '0);
	assign q_pop     = q_valid && (!active_q || finishing);

	// item sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (q_pop) begin
			active_q <= 1'b1;
			idx_q    <= q_data.start;
		end else if (active_q && load_ok) begin
			if (idx_q == '0) begin
				active_q <= 1'b0;
			end else begin
				idx_q <= idx_q - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			digits_q <= q_data.digits;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_ok) begin
			out_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && active_q) begin
			ascii_q <= ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, digits_q[idx_q]};
			last_q  <= (idx_q == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign ascii_digit = ascii_q;
	assign last_digit  = last_q;

endmodule

### rtl/core/binary_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top
// Formats an unsigned value as decimal ASCII digits, most significant first,
// with optional leading-zero suppression and a mark on the units digit.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   value, halfword_mode, keep_leading_zeros
//  out      output     out_valid / out_stall ascii_digit, last_digit
//
// The converter loads an item, then runs a double-dabble pass of four bits a
// cycle, and takes no new item until the last one is queued. The emitter sends
// one character a cycle while out_stall is low; the slower of the two sets the
// sustained rate.
// Reset clears all control state; there is no clearing pass.
// A queue between converter and emitter lets either side stall on its own.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top
	import btda_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic               halfword_mode,
	input  logic               keep_leading_zeros,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [ASCII_W-1:0] ascii_digit,
	output logic               last_digit
);

	logic        push;
	conv_entry_t push_entry;
	logic        queue_full;
	logic        q_pop;
	conv_entry_t q_data;
	logic        q_valid;

	// converter
	btda_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.value              (value),
		.halfword_mode      (halfword_mode),
		.keep_leading_zeros (keep_leading_zeros),
		.push               (push),
		.push_entry         (push_entry),
		.queue_full         (queue_full)
	);

	// decoupling queue
	btda_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_data  (push_entry),
		.full     (queue_full),
		.rd_en    (q_pop),
		.rd_data  (q_data),
		.rd_valid (q_valid)
	);

	// character emitter
	btda_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ascii_digit (ascii_digit),
		.last_digit  (last_digit)
	);

endmodule

### tb/binary_to_decimal_ascii_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_top_tb
// Self-checking bench for the decimal ASCII formatter. A queue of numbers is
// offered in bursts with random gaps. A digit predictor turns each accepted
// transaction into the expected character sequence. Every character that
// leaves the block is compared with the oldest expected one while the output
// side stalls on its own shifting pattern.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_top_tb;
	import btda_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 5;
	localparam int RANDOM_ITEMS = 280;
	localparam int IDLE_LIMIT   = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int MODE_CYCLES  = 50;

	// output stall behaviours, chosen at random during the run
	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_ALT,
		STALL_BURST
	} stall_mode_t;

	// one number to format, or a marker that makes the sender wait for drain
	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               halfword;
		logic               keep;
		bit                 pause;
	} number_req_t;

	// one character expected on the output
	typedef struct {
		logic [ASCII_W-1:0] code;
		logic               last;
	} char_exp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [VALUE_W-1:0] value = '0;
	logic               halfword_mode = 1'b0;
	logic               keep_leading_zeros = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [ASCII_W-1:0] ascii_digit;
	logic               last_digit;

	number_req_t pending_numbers[$];
	char_exp_t   expected_chars[$];

	logic in_fire = 1'b0;
	int   burst_left = 1;
	int   gap_left = 0;
	int   failures = 0;
	int   numbers_taken = 0;
	int   halfword_taken = 0;
	int   chars_checked = 0;
	int   drains_done = 0;
	int   idle_cycles = 0;
	int   stall_cycle = 0;
	int   hold_left = 0;
	bit   hold_done = 1'b0;
	stall_mode_t stall_mode = STALL_NONE;

	binary_to_decimal_ascii_top dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.value              (value),
		.halfword_mode      (halfword_mode),
		.keep_leading_zeros (keep_leading_zeros),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.ascii_digit        (ascii_digit),
		.last_digit         (last_digit)
	);

	// clock generation
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// split the number into decimal digits and queue the characters to be sent
	function automatic void predict_digits(input logic [VALUE_W-1:0] num_in,
			input logic halfword, input logic keep);
		int unsigned digs[5];
		int unsigned num;
		int          ndig;
		bit          sending;
		char_exp_t   ch;
		num     = halfword ? int'(num_in) : int'(num_in[7:0]);
		ndig    = halfword ? 5 : 3;
		sending = keep;
		for (int i = 0; i < ndig; i++) begin
			digs[i] = num % 10;
			num     = num / 10;
		end
		for (int i = ndig - 1; i >= 0; i--) begin
			if (i == 0 || sending || digs[i] != 0) begin
				sending = 1'b1;
				ch.code = ASCII_ZERO + ASCII_W'(digs[i]);
				ch.last = (i == 0);
				expected_chars.push_back(ch);
			end
		end
	endfunction

	function automatic void add_number(input logic [VALUE_W-1:0] v, input logic hw,
			input logic keep);
		number_req_t req;
		req.value    = v;
		req.halfword = hw;
		req.keep     = keep;
		req.pause    = 1'b0;
		pending_numbers.push_back(req);
	endfunction

	function automatic void add_drain_pause();
		number_req_t req;
		req.value    = '0;
		req.halfword = 1'b0;
		req.keep     = 1'b0;
		req.pause    = 1'b1;
		pending_numbers.push_back(req);
	endfunction

	// input capture, prediction and output checking at the rising edge
	always @(posedge clk) begin
		char_exp_t want;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				predict_digits(value, halfword_mode, keep_leading_zeros);
				numbers_taken++;
				if (halfword_mode)
					halfword_taken++;
			end
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected character transaction: ascii_digit %0d last_digit %0d",
						ascii_digit, last_digit);
					failures++;
				end else begin
					want = expected_chars.pop_front();
					if (ascii_digit !== want.code) begin
						$error("ascii_digit mismatch: expected %0d, got %0d",
							want.code, ascii_digit);
						failures++;
					end
					if (last_digit !== want.last) begin
						$error("last_digit mismatch: expected %0d, got %0d",
							want.last, last_digit);
						failures++;
					end
					chars_checked++;
				end
			end
		end
	end

	// sender: bursts of random length with random gaps, holds while stalled
	always @(negedge clk) begin
		number_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// stalled transaction stays put
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_numbers.size() == 0) begin
			in_valid <= 1'b0;
		end else if (pending_numbers[0].pause) begin
			in_valid <= 1'b0;
			if (expected_chars.size() == 0) begin
				void'(pending_numbers.pop_front());
				drains_done++;
			end
		end else begin
			req                = pending_numbers.pop_front();
			value              <= req.value;
			halfword_mode      <= req.halfword;
			keep_leading_zeros <= req.keep;
			in_valid           <= 1'b1;
			if (burst_left <= 1) begin
				burst_left = $urandom_range(1, 16);
				gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	end

	// receiver: shifting stall pattern plus one long hold-off to fill the block
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			stall_cycle++;
			if (stall_cycle % MODE_CYCLES == 0)
				stall_mode = stall_mode_t'($urandom_range(0, 4));
			if (!hold_done && chars_checked >= 250) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					STALL_ALT:   out_stall <= stall_cycle[0];
					default:     out_stall <= (stall_cycle % 8 < 3);
				endcase
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired after %0d idle cycles", idle_cycles);
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [VALUE_W-1:0] v;

		// directed: extremes, zero, wide value in byte mode, digit boundaries
		add_number(16'd0, 1'b1, 1'b0);
		add_number(16'd0, 1'b1, 1'b1);
		add_number(16'd0, 1'b0, 1'b0);
		add_number(16'd0, 1'b0, 1'b1);
		add_number(16'hFFFF, 1'b1, 1'b0);
		add_number(16'hFFFF, 1'b1, 1'b1);
		add_number(16'hFFFF, 1'b0, 1'b0);
		add_number(16'h00FF, 1'b0, 1'b1);
		add_number(16'hFF00, 1'b0, 1'b0);
		add_number(16'hFF00, 1'b0, 1'b1);
		add_number(16'h0105, 1'b0, 1'b0);
		add_number(16'd10000, 1'b1, 1'b0);
		add_number(16'd9999, 1'b1, 1'b0);
		add_number(16'd1000, 1'b1, 1'b0);
		add_number(16'd100, 1'b1, 1'b0);
		add_number(16'd99, 1'b1, 1'b0);
		add_number(16'd10, 1'b1, 1'b0);
		add_number(16'd9, 1'b1, 1'b0);
		add_number(16'd1, 1'b1, 1'b1);
		add_number(16'd200, 1'b0, 1'b0);
		add_number(16'd100, 1'b0, 1'b0);
		add_number(16'd50, 1'b0, 1'b1);
		add_number(16'd7, 1'b0, 1'b0);
		add_drain_pause();

		// random: full range, small numbers for the zero suppression, two random bytes
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case ($urandom_range(0, 3))
				0: v = VALUE_W'($urandom_range(0, 65535));
				1: v = VALUE_W'($urandom_range(0, 999));
				2: v = VALUE_W'($urandom_range(0, 99));
				default: v = {8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
			endcase
			add_number(v, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if (n == RANDOM_ITEMS / 2)
				add_drain_pause();
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_numbers.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("formatted %0d numbers (%0d halfword, %0d byte), %0d characters checked",
			numbers_taken, halfword_taken, numbers_taken - halfword_taken, chars_checked);
		$display("long output hold-off applied: %0d, drain pauses: %0d", hold_done,
			drains_done);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
